/* hdl/ympr_pkg.sv */
// Shared types and constants for the YMODEM packet receiver.
package ympr_pkg;

    localparam int VALUE_W     = 27;
    localparam int MAX_RESULTS = 4;
    localparam int SHORT_PAYLOAD = 128;

    // Framing and reply characters.
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CA  = 8'h18;
    localparam logic [7:0] CH_CRC = 8'h43;
    localparam logic [7:0] CH_AB1 = 8'h41;
    localparam logic [7:0] CH_AB2 = 8'h61;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Session end status codes.
    localparam logic [VALUE_W-1:0] ST_DONE      = 27'd0;
    localparam logic [VALUE_W-1:0] ST_CANCELLED = 27'd1;
    localparam logic [VALUE_W-1:0] ST_TOO_LARGE = 27'd2;
    localparam logic [VALUE_W-1:0] ST_ERRORS    = 27'd3;
    localparam logic [VALUE_W-1:0] ST_ABORT     = 27'd4;

    localparam logic [VALUE_W-1:0] SIZE_SAT = 27'h7FFFFFF;
    localparam logic [7:0]         MAX_ERRORS_RESET = 8'd5;
    localparam logic [VALUE_W-1:0] MAX_FILE_SIZE_RESET = 27'h5FFFFFF;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MAX_ERRORS    = 2'd0,
        CFG_MAX_FILE_SIZE = 2'd1
    } cfg_index_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CA2,
        PH_SEQ,
        PH_COMP,
        PH_KEEP,
        PH_NAK,
        PH_BAD
    } phase_t;

    typedef enum logic [2:0] {
        K_PAY     = 3'd0,
        K_NAME    = 3'd1,
        K_SIZE    = 3'd2,
        K_COMMIT  = 3'd3,
        K_DISCARD = 3'd4,
        K_REPLY   = 3'd5,
        K_END     = 3'd6
    } kind_t;

    // All results caused by one request.
    typedef struct packed {
        logic [2:0]                          count;
        kind_t [MAX_RESULTS-1:0]             kind;
        logic [MAX_RESULTS-1:0][VALUE_W-1:0] value;
    } bundle_t;

    // Append one result to a bundle.
    function automatic bundle_t put(bundle_t b, kind_t k, logic [VALUE_W-1:0] v);
        bundle_t r;
        r = b;
        r.kind[b.count[1:0]]  = k;
        r.value[b.count[1:0]] = v;
        r.count = b.count + 3'd1;
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] ch(logic [7:0] c);
        return {{(VALUE_W-8){1'b0}}, c};
    endfunction

endpackage

/* hdl/ympr_front.sv */
// Front part: accepts requests, runs the protocol state and builds result bundles.
module ympr_front #(
    parameter int LONG_PAYLOAD    = 1024,
    parameter int NAME_MAX        = 64,
    parameter int SIZE_DIGITS_MAX = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      action,
    input  logic [7:0]                rx_byte,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [ympr_pkg::VALUE_W-1:0] cfg_data,
    input  logic                      q_full,
    output logic                      push,
    output ympr_pkg::bundle_t         push_data
);
    import ympr_pkg::*;

    localparam int BC_W = $clog2(LONG_PAYLOAD + 2);
    localparam int NI_W = $clog2(NAME_MAX);
    localparam int SD_W = $clog2(SIZE_DIGITS_MAX + 1);

    phase_t             phase_reg, phase_next;
    logic [BC_W-1:0]    byte_count_reg, byte_count_next;
    logic               long_reg, long_next;
    logic [7:0]         seq_reg, seq_next;
    logic [7:0]         exp_seq_reg, exp_seq_next;
    logic               past_first_reg, past_first_next;
    logic [7:0]         err_reg, err_next;
    logic               started_reg, started_next;
    logic [NI_W-1:0]    name_index_reg, name_index_next;
    logic [1:0]         nfp_reg, nfp_next;
    logic [VALUE_W-1:0] size_reg, size_next;
    logic [SD_W-1:0]    digits_reg, digits_next;
    logic               name_empty_reg, name_empty_next;
    logic [7:0]         max_errors_reg;
    logic [VALUE_W-1:0] max_size_reg;

    logic               accept;
    logic               do_fail, drop, do_finish, do_clear;
    logic [BC_W-1:0]    plen;
    logic [VALUE_W+3:0] size_wide;
    logic [SD_W-1:0]    digits_inc;
    bundle_t            res;

    assign in_stall  = q_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign plen      = long_reg ? BC_W'(LONG_PAYLOAD) : BC_W'(SHORT_PAYLOAD);
    assign size_wide = ({4'd0, size_reg} << 3) + ({4'd0, size_reg} << 1)
                     + (VALUE_W+4)'(rx_byte - CH_ZERO);
    assign digits_inc = digits_reg + SD_W'(1);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_errors_reg <= MAX_ERRORS_RESET;
            max_size_reg   <= MAX_FILE_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MAX_ERRORS)
                max_errors_reg <= cfg_data[7:0];
            else if (cfg_index == CFG_MAX_FILE_SIZE)
                max_size_reg <= cfg_data;
        end
    end

    // Protocol state and result generation for one request.
    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        long_next       = long_reg;
        seq_next        = seq_reg;
        exp_seq_next    = exp_seq_reg;
        past_first_next = past_first_reg;
        err_next        = err_reg;
        started_next    = started_reg;
        name_index_next = name_index_reg;
        nfp_next        = nfp_reg;
        size_next       = size_reg;
        digits_next     = digits_reg;
        name_empty_next = name_empty_reg;
        res       = '0;
        do_fail   = 1'b0;
        drop      = 1'b0;
        do_finish = 1'b0;
        do_clear  = 1'b0;

        if (accept)
        begin
            if (action)
            begin
                do_fail = 1'b1;
                drop    = (phase_reg == PH_KEEP);
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (rx_byte == CH_SOH || rx_byte == CH_STX)
                        begin
                            long_next  = (rx_byte == CH_STX);
                            phase_next = PH_SEQ;
                        end
                        else if (rx_byte == CH_EOT)
                        begin
                            err_next        = '0;
                            exp_seq_next    = '0;
                            past_first_next = 1'b0;
                            res = put(res, K_REPLY, ch(CH_ACK));
                        end
                        else if (rx_byte == CH_CA)
                            phase_next = PH_CA2;
                        else if (rx_byte == CH_AB1 || rx_byte == CH_AB2)
                        begin
                            res = put(res, K_REPLY, ch(CH_CA));
                            res = put(res, K_REPLY, ch(CH_CA));
                            res = put(res, K_END, ST_ABORT);
                            do_clear = 1'b1;
                        end
                        else
                            do_fail = 1'b1;
                    end
                    PH_CA2:
                    begin
                        if (rx_byte == CH_CA)
                        begin
                            res = put(res, K_REPLY, ch(CH_ACK));
                            res = put(res, K_END, ST_CANCELLED);
                            do_clear = 1'b1;
                        end
                        else
                            do_fail = 1'b1;
                    end
                    PH_SEQ:
                    begin
                        seq_next   = rx_byte;
                        phase_next = PH_COMP;
                    end
                    PH_COMP:
                    begin
                        if (seq_reg != ~rx_byte)
                            phase_next = PH_BAD;
                        else if (seq_reg != exp_seq_reg)
                            phase_next = PH_NAK;
                        else
                            phase_next = PH_KEEP;
                        byte_count_next = '0;
                        name_index_next = '0;
                        nfp_next        = '0;
                        size_next       = '0;
                        digits_next     = '0;
                        name_empty_next = 1'b0;
                    end
                    PH_KEEP, PH_NAK, PH_BAD:
                    begin
                        if (phase_reg == PH_KEEP && byte_count_reg < plen)
                        begin
                            if (past_first_reg)
                                res = put(res, K_PAY, ch(rx_byte));
                            else
                            begin
                                // File name, then the decimal size.
                                unique case (nfp_reg)
                                    2'd0:
                                    begin
                                        if (rx_byte == CH_NUL)
                                        begin
                                            if (byte_count_reg == '0)
                                                name_empty_next = 1'b1;
                                            nfp_next = 2'd2;
                                        end
                                        else
                                        begin
                                            res = put(res, K_NAME, ch(rx_byte));
                                            if (name_index_reg == NI_W'(NAME_MAX - 1))
                                                nfp_next = 2'd1;
                                            else
                                                name_index_next = name_index_reg + NI_W'(1);
                                        end
                                    end
                                    2'd1:
                                        nfp_next = 2'd2;
                                    2'd2:
                                    begin
                                        if (rx_byte == CH_SPACE || rx_byte == CH_NUL)
                                            nfp_next = 2'd3;
                                        else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE)
                                        begin
                                            size_next = (size_wide[VALUE_W+3:VALUE_W] != '0)
                                                      ? SIZE_SAT : size_wide[VALUE_W-1:0];
                                            digits_next = digits_inc;
                                            if (digits_inc >= SD_W'(SIZE_DIGITS_MAX))
                                                nfp_next = 2'd3;
                                        end
                                        else
                                        begin
                                            size_next = '0;
                                            nfp_next  = 2'd3;
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                        if (byte_count_reg == plen + BC_W'(1))
                            do_finish = 1'b1;
                        else
                            byte_count_next = byte_count_reg + BC_W'(1);
                    end
                    default:
                        do_clear = 1'b1;
                endcase
            end

            // End of packet.
            if (do_finish)
            begin
                phase_next      = PH_IDLE;
                byte_count_next = '0;
                if (phase_reg == PH_BAD)
                    do_fail = 1'b1;
                else
                begin
                    err_next = '0;
                    if (phase_reg == PH_NAK)
                        res = put(res, K_REPLY, ch(CH_NAK));
                    else
                    begin
                        if (past_first_reg)
                        begin
                            res = put(res, K_COMMIT, '0);
                            res = put(res, K_REPLY, ch(CH_ACK));
                        end
                        else if (name_empty_reg)
                        begin
                            res = put(res, K_REPLY, ch(CH_ACK));
                            res = put(res, K_END, ST_DONE);
                            do_clear = 1'b1;
                        end
                        else if (size_reg > max_size_reg)
                        begin
                            res = put(res, K_DISCARD, '0);
                            res = put(res, K_REPLY, ch(CH_CA));
                            res = put(res, K_REPLY, ch(CH_CA));
                            res = put(res, K_END, ST_TOO_LARGE);
                            do_clear = 1'b1;
                        end
                        else
                        begin
                            res = put(res, K_SIZE, size_reg);
                            res = put(res, K_COMMIT, '0);
                            res = put(res, K_REPLY, ch(CH_ACK));
                            res = put(res, K_REPLY, ch(CH_CRC));
                            past_first_next = 1'b1;
                        end
                        exp_seq_next = exp_seq_reg + 8'd1;
                        started_next = 1'b1;
                    end
                end
            end

            // Error path.
            if (do_fail)
            begin
                if (drop)
                    res = put(res, K_DISCARD, '0);
                phase_next      = PH_IDLE;
                byte_count_next = '0;
                if (started_reg && err_reg >= max_errors_reg)
                begin
                    res = put(res, K_REPLY, ch(CH_CA));
                    res = put(res, K_REPLY, ch(CH_CA));
                    res = put(res, K_END, ST_ERRORS);
                    do_clear = 1'b1;
                end
                else
                begin
                    if (started_reg)
                        err_next = err_reg + 8'd1;
                    res = put(res, K_REPLY, ch(CH_CRC));
                end
            end

            // Session end returns all protocol state to reset.
            if (do_clear)
            begin
                phase_next      = PH_IDLE;
                byte_count_next = '0;
                long_next       = 1'b0;
                seq_next        = '0;
                exp_seq_next    = '0;
                past_first_next = 1'b0;
                err_next        = '0;
                started_next    = 1'b0;
                name_index_next = '0;
                nfp_next        = '0;
                size_next       = '0;
                digits_next     = '0;
                name_empty_next = 1'b0;
            end
        end
    end

    assign push      = accept && (res.count != 3'd0);
    assign push_data = res;

    // Protocol state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_count_reg <= '0;
            long_reg       <= 1'b0;
            seq_reg        <= '0;
            exp_seq_reg    <= '0;
            past_first_reg <= 1'b0;
            err_reg        <= '0;
            started_reg    <= 1'b0;
            name_index_reg <= '0;
            nfp_reg        <= '0;
            size_reg       <= '0;
            digits_reg     <= '0;
            name_empty_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            long_reg       <= long_next;
            seq_reg        <= seq_next;
            exp_seq_reg    <= exp_seq_next;
            past_first_reg <= past_first_next;
            err_reg        <= err_next;
            started_reg    <= started_next;
            name_index_reg <= name_index_next;
            nfp_reg        <= nfp_next;
            size_reg       <= size_next;
            digits_reg     <= digits_next;
            name_empty_reg <= name_empty_next;
        end
    end

    // The byte counter only runs inside a packet body.
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE || phase_reg == PH_CA2 || phase_reg == PH_SEQ)
        |-> byte_count_reg == '0)
        else $error("byte counter nonzero outside packet body");

    // Errors are only counted once a session has started.
    a_err_session: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> err_reg == '0)
        else $error("error count outside a session");

endmodule

/* hdl/ympr_queue.sv */
// Two-entry queue of result bundles between the front and back parts.
module ympr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ympr_pkg::bundle_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output ympr_pkg::bundle_t head
);
    import ympr_pkg::*;

    bundle_t    entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("pop from empty queue");

endmodule

/* hdl/ympr_back.sv */
// Back part: unpacks bundles into single results behind an output register.
module ympr_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  ympr_pkg::bundle_t            q_head,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   out_kind,
    output logic [ympr_pkg::VALUE_W-1:0] out_value,
    output logic                         last
);
    import ympr_pkg::*;

    bundle_t            bundle_reg;
    logic [1:0]         idx_reg;
    logic               busy_reg;
    logic               valid_reg;
    kind_t              kind_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               last_reg;
    logic               advance;

    assign advance   = !valid_reg || !out_stall;
    assign q_pop     = advance && !busy_reg && q_valid;
    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_value = value_reg;
    assign last      = last_reg;

    // Output register payload and the bundle being drained.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (busy_reg)
            begin
                kind_reg  <= bundle_reg.kind[idx_reg];
                value_reg <= bundle_reg.value[idx_reg];
                last_reg  <= ({1'b0, idx_reg} + 3'd1 == bundle_reg.count);
            end
            else if (q_valid)
            begin
                kind_reg   <= q_head.kind[0];
                value_reg  <= q_head.value[0];
                last_reg   <= (q_head.count == 3'd1);
                bundle_reg <= q_head;
            end
        end
    end

    // Control: output valid, drain index and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else if (advance)
        begin
            if (busy_reg)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= idx_reg + 2'd1;
                if ({1'b0, idx_reg} + 3'd1 == bundle_reg.count)
                    busy_reg <= 1'b0;
            end
            else if (q_valid)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= 2'd1;
                busy_reg  <= (q_head.count != 3'd1);
            end
            else
                valid_reg <= 1'b0;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, idx_reg} < bundle_reg.count))
        else $error("drain index past bundle end");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !busy_reg)
        else $error("bundle popped while another is draining");

endmodule

/* hdl/ymodem_packet_receiver_unit.sv */
// Top level of the YMODEM packet receiver.
// Input channel (in_valid/in_stall): one request per received byte or timeout;
// action=1 marks a timeout, rx_byte carries the byte otherwise.
// Output channel (out_valid/out_stall): zero to four results per request, in
// order, each with out_kind, out_value, and last on the final one of a request.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
// max_errors, index 1 is max_file_size; cfg_ready is always high.
// The first result of a request passes through the bundle queue and then the
// output register before it is on the output and can be taken.
// Throughput: one request per cycle while the bundle queue has room; results
// leave the output register one at a time, while out_stall is low.
// The front accepts while the two-entry bundle queue has room, so the drain
// rate of the output register sets the sustained rate under long replies.
// At reset the session state clears, max_errors becomes 5 and max_file_size
// becomes 0x5FFFFFF. When the receiver stalls, the output holds, the queue
// fills, and in_stall rises once both queue entries are taken.
module ymodem_packet_receiver_unit #(
    parameter int LONG_PAYLOAD    = 1024,
    parameter int NAME_MAX        = 64,
    parameter int SIZE_DIGITS_MAX = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic [7:0]                   rx_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   out_kind,
    output logic [ympr_pkg::VALUE_W-1:0] out_value,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [ympr_pkg::VALUE_W-1:0] cfg_data
);
    import ympr_pkg::*;

    logic    push, q_full, q_valid, q_pop;
    bundle_t push_data, q_head;

    ympr_front #(
        .LONG_PAYLOAD    (LONG_PAYLOAD),
        .NAME_MAX        (NAME_MAX),
        .SIZE_DIGITS_MAX (SIZE_DIGITS_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    ympr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    ympr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (out_kind),
        .out_value (out_value),
        .last      (last)
    );

endmodule
